>>> hdl/ps2_mouse_packet_cursor_defines.svh
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_defines.svh
// Assertion macros shared by the PS/2 mouse cursor RTL.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH
`define PS2_MOUSE_PACKET_CURSOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PS2MC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define PS2MC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ps2mc_pkg.sv
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Shared widths, constants, codes and types of the PS/2 mouse cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mc_pkg;

  // Field and bus widths
  localparam int BYTE_W         = 8;
  localparam int SIZE_W         = 13;
  localparam int POS_W          = 12;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;
  localparam int REG_IDX_BIT    = 2;
  localparam int COORD_BITS_DEF = 12;

  // Reset values
  localparam int CURSOR_RESET = 20;
  localparam int WIDTH_RESET  = 1024;
  localparam int HEIGHT_RESET = 768;

  // Flags byte bit positions
  localparam int FLG_LEFT  = 0;
  localparam int FLG_RIGHT = 1;
  localparam int FLG_ONE   = 3;
  localparam int FLG_XSIGN = 4;
  localparam int FLG_YSIGN = 5;
  localparam int FLG_XOVF  = 6;
  localparam int FLG_YOVF  = 7;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    PH_FLAGS  = 2'd0,
    PH_XDELTA = 2'd1,
    PH_YDELTA = 2'd2
  } phase_t;

  // Configuration register indexes
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // Byte handed from the input stage to the decode stage
  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } step_t;

  // Current screen size
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
  } cfg_t;

endpackage

`default_nettype wire

>>> hdl/ps2mc_ifs.sv
// ----------------------------------------------------------------------------
// ps2mc_ifs
// Valid/ready channels: received mouse bytes in, cursor results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ps2mc_in_if;
  import ps2mc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mc_out_if;
  import ps2mc_pkg::*;

  logic             valid;
  logic             ready;
  logic             packet_dropped;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             left_button;
  logic             right_button;

  modport source (output valid, output packet_dropped, output pos_x, output pos_y,
                  output left_button, output right_button, input ready);
  modport sink   (input valid, input packet_dropped, input pos_x, input pos_y,
                  input left_button, input right_button, output ready);
endinterface

`default_nettype wire

>>> hdl/ps2mc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ps2mc_cfg_regs
// APB register file holding the screen width and height.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2mc_pkg::APB_AW-1:0]  paddr,
  input  logic [ps2mc_pkg::APB_DW-1:0]  pwdata,
  output logic [ps2mc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output ps2mc_pkg::cfg_t               cfg
);
  import ps2mc_pkg::*;

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              wr_en;
  cfg_reg_t          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_t'(paddr[REG_IDX_BIT]);

  // Register writes, only the low bits of the data are kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(WIDTH_RESET);
      height_r <= SIZE_W'(HEIGHT_RESET);
    end else if (wr_en) begin
      case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

`default_nettype wire

>>> hdl/ps2mc_axis.sv
// ----------------------------------------------------------------------------
// ps2mc_axis
// One cursor axis: applies an 8-bit delta and clamps to [1, size-1] and the coordinate range.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_axis #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]         cur,
  input  logic [ps2mc_pkg::BYTE_W-1:0]  delta,
  input  logic                          negative,
  input  logic                          subtract,
  input  logic [ps2mc_pkg::SIZE_W-1:0]  size,
  output logic [COORD_BITS-1:0]         nxt
);
  import ps2mc_pkg::*;

  localparam int CW       = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
  localparam int CoordMax = (1 << COORD_BITS) - 1;

  logic signed [BYTE_W+1:0] dval;
  logic signed [CW-1:0]     sum;
  logic signed [CW-1:0]     lo_clamped;
  logic [SIZE_W-1:0]        hi_raw;
  logic signed [CW-1:0]     hi_ext;
  logic signed [CW-1:0]     hi;
  logic signed [CW-1:0]     res;

  // Delta: sign-extended only when the sign flag is set
  assign dval = negative ? $signed({{2{delta[BYTE_W-1]}}, delta})
                         : $signed({2'b00, delta});

  // Move
  always_comb begin
    if (subtract) begin
      sum = $signed(CW'(cur)) - CW'(dval);
    end else begin
      sum = $signed(CW'(cur)) + CW'(dval);
    end
  end

  // Lower bound first
  assign lo_clamped = (sum <= $signed(CW'(1))) ? $signed(CW'(1)) : sum;

  // Upper bound: size-1 saturated at zero and at the coordinate range
  assign hi_raw = (size == '0) ? '0 : size - SIZE_W'(1);
  assign hi_ext = $signed(CW'(hi_raw));
  assign hi     = (hi_ext > $signed(CW'(CoordMax))) ? $signed(CW'(CoordMax)) : hi_ext;

  // Upper bound wins
  assign res = (lo_clamped >= hi) ? hi : lo_clamped;
  assign nxt = res[COORD_BITS-1:0];

endmodule

`default_nettype wire

>>> hdl/ps2mc_core.sv
// ----------------------------------------------------------------------------
// ps2mc_core
// Packet assembly, drop check, cursor and button state, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_core #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ps2mc_pkg::step_t  step,
  input  ps2mc_pkg::cfg_t   cfg,
  output logic              step_ready,
  ps2mc_out_if.source       out_chan
);
  import ps2mc_pkg::*;

  phase_t                  phase_r, phase_nxt;
  logic [BYTE_W-1:0]       flags_r;
  logic [BYTE_W-1:0]       xdelta_r;
  logic                    drop_r;
  logic [COORD_BITS-1:0]   col_r, row_r;
  logic [1:0]              btn_r;
  logic                    out_valid_r;
  logic                    res_drop_r;
  logic [POS_W-1:0]        res_x_r, res_y_r;
  logic [1:0]              res_btn_r;

  logic                    take;
  logic                    ld_flags, ld_x, ld_last;
  logic                    is_last;
  logic                    drop_byte;
  logic [COORD_BITS-1:0]   col_new, row_new;
  logic [COORD_BITS-1:0]   col_upd, row_upd;
  logic [1:0]              btn_upd;

  // A final byte waits only if the result register is still full
  assign is_last    = (phase_r == PH_YDELTA);
  assign step_ready = !is_last || !out_valid_r || out_chan.ready;
  assign take       = step.vld && step_ready;

  // Next phase; the unused code behaves as a flags phase
  always_comb begin
    case (phase_r)
      PH_FLAGS:  phase_nxt = PH_XDELTA;
      PH_XDELTA: phase_nxt = PH_YDELTA;
      PH_YDELTA: phase_nxt = PH_FLAGS;
      default:   phase_nxt = PH_XDELTA;
    endcase
  end

  // Per-phase load strobes
  always_comb begin
    ld_flags = 1'b0;
    ld_x     = 1'b0;
    ld_last  = 1'b0;
    case (phase_r)
      PH_XDELTA: ld_x     = take;
      PH_YDELTA: ld_last  = take;
      default:   ld_flags = take;
    endcase
  end

  assign drop_byte = step.data[FLG_XOVF] | step.data[FLG_YOVF] | ~step.data[FLG_ONE];

  // Axis updates
  ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .cur      (col_r),
    .delta    (xdelta_r),
    .negative (flags_r[FLG_XSIGN]),
    .subtract (1'b0),
    .size     (cfg.width),
    .nxt      (col_new)
  );

  ps2mc_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .cur      (row_r),
    .delta    (step.data),
    .negative (flags_r[FLG_YSIGN]),
    .subtract (1'b1),
    .size     (cfg.height),
    .nxt      (row_new)
  );

  // A dropped packet leaves cursor and buttons alone
  assign col_upd = drop_r ? col_r : col_new;
  assign row_upd = drop_r ? row_r : row_new;
  assign btn_upd = drop_r ? btn_r : {flags_r[FLG_RIGHT], flags_r[FLG_LEFT]};

  // Packet and cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAGS;
      flags_r  <= '0;
      xdelta_r <= '0;
      drop_r   <= 1'b0;
      col_r    <= COORD_BITS'(CURSOR_RESET);
      row_r    <= COORD_BITS'(CURSOR_RESET);
      btn_r    <= '0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
      end
      if (ld_flags) begin
        flags_r <= step.data;
        drop_r  <= drop_byte;
      end
      if (ld_x) begin
        xdelta_r <= step.data;
      end
      if (ld_last) begin
        col_r  <= col_upd;
        row_r  <= row_upd;
        btn_r  <= btn_upd;
        drop_r <= 1'b0;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld_last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ld_last) begin
      res_drop_r <= drop_r;
      res_x_r    <= POS_W'(col_upd);
      res_y_r    <= POS_W'(row_upd);
      res_btn_r  <= btn_upd;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.packet_dropped = res_drop_r;
  assign out_chan.pos_x          = res_x_r;
  assign out_chan.pos_y          = res_y_r;
  assign out_chan.left_button    = res_btn_r[0];
  assign out_chan.right_button   = res_btn_r[1];

endmodule

`default_nettype wire

>>> hdl/ps2_mouse_packet_cursor.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor: PS/2 mouse packet decoder with cursor tracking
// One byte per cycle unless a full result register holds back a final byte; each third byte yields a result.
// Input register, then decode/add/clamp into the result register.
// Sync active-low reset: cursor (20,20), buttons released, flags byte expected.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ps2_mouse_packet_cursor_defines.svh"

module ps2_mouse_packet_cursor #(
  parameter int COORD_BITS = ps2mc_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ps2mc_in_if.sink                      in_chan,
  ps2mc_out_if.source                   out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2mc_pkg::APB_AW-1:0]  paddr,
  input  logic [ps2mc_pkg::APB_DW-1:0]  pwdata,
  output logic [ps2mc_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);
  import ps2mc_pkg::*;

  logic              in_valid_r, in_valid_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_take;
  logic              step_ready;
  step_t             step;
  cfg_t              cfg;

  // Configuration registers
  ps2mc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register
  assign in_chan.ready = !in_valid_r || step_ready;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step_ready) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_chan.rx_byte;
    end
  end

  assign step.vld  = in_valid_r;
  assign step.data = in_byte_r;

  // Decode and cursor update
  ps2mc_core #(.COORD_BITS(COORD_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cfg        (cfg),
    .step_ready (step_ready),
    .out_chan   (out_chan)
  );

  // Checks
  `PS2MC_ASSERT_NEXT(a_stalled_byte_held, in_valid_r && !step_ready,
    in_valid_r && $stable(in_byte_r), "stalled byte lost or changed")
  `PS2MC_ASSERT_NOW(a_stall_needs_full_result, in_valid_r && !step_ready,
    out_chan.valid && !out_chan.ready, "decode stalled without a pending result")
  `PS2MC_ASSERT_NOW(a_backpressure_source, !in_chan.ready,
    in_valid_r, "input blocked with an empty input register")

endmodule

`default_nettype wire

>>> bench/ps2_mouse_packet_cursor_tb.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tb
// Self-checking bench for the PS/2 mouse packet decoder: a directed byte
// table, then random packet traffic under several screen sizes, with random
// stalls on both channels. Every result is compared against an in-bench
// cursor tracker or against a hand-written report from the directed table.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TARGET_ITEMS = 1550;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 192;
  localparam int DRAIN_CYCLES = 8;
  localparam int COORD_LIMIT  = (1 << POS_W) - 1;
  localparam int N_ROWS       = 24;

  // One cursor report as seen on the result channel
  typedef struct packed {
    logic             dropped;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             left;
    logic             right;
  } cursor_rpt_t;

  // Directed row: one byte, optionally with a hand-written report
  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              typed;
    cursor_rpt_t       rpt;
  } stim_row_t;

  localparam cursor_rpt_t NO_RPT = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  ps2mc_in_if  in_if ();
  ps2mc_out_if out_if ();

  ps2_mouse_packet_cursor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #HALF_PERIOD clk = ~clk;

  // Directed bytes: clean packet at reset, each drop reason, extreme deltas
  stim_row_t dir_rows [N_ROWS] = '{
    '{8'h08, 1'b0, NO_RPT}, '{8'h00, 1'b0, NO_RPT},
    '{8'h00, 1'b1, '{1'b0, 12'd20, 12'd20, 1'b0, 1'b0}},
    '{8'h00, 1'b0, NO_RPT}, '{8'h05, 1'b0, NO_RPT},
    '{8'h05, 1'b1, '{1'b1, 12'd20, 12'd20, 1'b0, 1'b0}},
    '{8'h48, 1'b0, NO_RPT}, '{8'h7F, 1'b0, NO_RPT},
    '{8'h7F, 1'b1, '{1'b1, 12'd20, 12'd20, 1'b0, 1'b0}},
    '{8'h88, 1'b0, NO_RPT}, '{8'h81, 1'b0, NO_RPT},
    '{8'h81, 1'b1, '{1'b1, 12'd20, 12'd20, 1'b0, 1'b0}},
    '{8'h1B, 1'b0, NO_RPT}, '{8'h80, 1'b0, NO_RPT},
    '{8'h00, 1'b1, '{1'b0, 12'd1, 12'd20, 1'b1, 1'b1}},
    '{8'h28, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'h80, 1'b1, '{1'b0, 12'd256, 12'd148, 1'b0, 1'b0}},
    '{8'h38, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT},
    '{8'h0D, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}, '{8'hFF, 1'b0, NO_RPT}
  };

  // Tracker state
  phase_t            trk_phase;
  logic [BYTE_W-1:0] trk_flags;
  logic [BYTE_W-1:0] trk_xdelta;
  logic              trk_drop;
  logic [POS_W-1:0]  trk_col;
  logic [POS_W-1:0]  trk_row;
  logic [1:0]        trk_buttons;
  logic [SIZE_W-1:0] scr_width;
  logic [SIZE_W-1:0] scr_height;

  cursor_rpt_t pending_rpts [$];
  int          err_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          rx_stall_left = 0;
  bit          rx_stall_on = 1'b1;
  bit          tx_gaps_on = 1'b1;

  function automatic int delta_of(logic [BYTE_W-1:0] raw, logic neg);
    if (neg && raw[BYTE_W-1]) return int'(raw) - 256;
    return int'(raw);
  endfunction

  // Lower bound 1 first, then the screen bound (saturated to the coordinate range)
  function automatic logic [POS_W-1:0] clamp_to_screen(int v, logic [SIZE_W-1:0] size);
    int hi;
    hi = int'(size) - 1;
    if (v <= 1) v = 1;
    if (hi < 0) hi = 0;
    if (hi > COORD_LIMIT) hi = COORD_LIMIT;
    if (v >= hi) v = hi;
    return v[POS_W-1:0];
  endfunction

  task automatic reset_tracker();
    trk_phase   = PH_FLAGS;
    trk_flags   = '0;
    trk_xdelta  = '0;
    trk_drop    = 1'b0;
    trk_col     = POS_W'(CURSOR_RESET);
    trk_row     = POS_W'(CURSOR_RESET);
    trk_buttons = 2'b00;
    scr_width   = SIZE_W'(WIDTH_RESET);
    scr_height  = SIZE_W'(HEIGHT_RESET);
  endtask

  // Advance the cursor tracker by one accepted byte
  task automatic track_mouse_byte(input logic [BYTE_W-1:0] b, output bit got,
                                  output cursor_rpt_t r);
    int dx;
    int dy;
    got = 1'b0;
    r   = NO_RPT;
    case (trk_phase)
      PH_XDELTA: begin
        trk_xdelta = b;
        trk_phase  = PH_YDELTA;
      end
      PH_YDELTA: begin
        trk_phase = PH_FLAGS;
        if (!trk_drop) begin
          dx = delta_of(trk_xdelta, trk_flags[FLG_XSIGN]);
          dy = delta_of(b, trk_flags[FLG_YSIGN]);
          trk_col = clamp_to_screen(int'(trk_col) + dx, scr_width);
          trk_row = clamp_to_screen(int'(trk_row) - dy, scr_height);
          trk_buttons = {trk_flags[FLG_RIGHT], trk_flags[FLG_LEFT]};
        end
        r.dropped = trk_drop;
        r.pos_x   = trk_col;
        r.pos_y   = trk_row;
        r.left    = trk_buttons[0];
        r.right   = trk_buttons[1];
        got       = 1'b1;
        trk_drop  = 1'b0;
      end
      default: begin
        trk_flags = b;
        trk_phase = PH_XDELTA;
        trk_drop  = b[FLG_XOVF] | b[FLG_YOVF] | ~b[FLG_ONE];
      end
    endcase
  endtask

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      err_count++;
    end
  endtask

  // Drive one byte after a gap; valid stays up when the next byte follows at once
  task automatic send_byte(input logic [BYTE_W-1:0] b, input bit use_typed,
                           input cursor_rpt_t typed_rpt);
    int          gap;
    bit          got;
    cursor_rpt_t r;
    gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    track_mouse_byte(b, got, r);
    if (got) pending_rpts.push_back(use_typed ? typed_rpt : r);
    items_sent++;
  endtask

  // Stop sending and let the pipeline empty
  task automatic wait_idle(int extra);
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_rpts.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Register write, then readback of the same register
  task automatic cfg_set(cfg_reg_t idx, logic [APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << REG_IDX_BIT;
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_WIDTH) scr_width = val[SIZE_W-1:0];
    else scr_height = val[SIZE_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field(idx == REG_WIDTH ? "prdata(screen_width)" : "prdata(screen_height)",
                int'(val[SIZE_W-1:0]), int'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random packet, a broken one, or a stray byte that shifts the framing
  task automatic send_random_unit();
    int                kind;
    logic [BYTE_W-1:0] flg;
    kind = $urandom_range(0, 99);
    flg  = BYTE_W'($urandom);
    if (kind < 75) begin
      flg[FLG_ONE]  = 1'b1;
      flg[FLG_XOVF] = 1'b0;
      flg[FLG_YOVF] = 1'b0;
    end else if (kind < 88) begin
      flg[FLG_ONE] = 1'b1;
      if ($urandom_range(0, 1)) flg[FLG_XOVF] = 1'b1;
      else flg[FLG_YOVF] = 1'b1;
    end
    send_byte(flg, 1'b0, NO_RPT);
    if (kind < 96) begin
      send_byte(BYTE_W'($urandom), 1'b0, NO_RPT);
      send_byte(BYTE_W'($urandom), 1'b0, NO_RPT);
    end
  endtask

  // Result side: ready drops while a stall is counting down
  always @(negedge clk) begin
    out_if.ready <= (rx_stall_left == 0);
  end

  // Compare with the oldest report, then draw the stall before the next one
  always @(posedge clk) begin
    cursor_rpt_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_rpts.size() == 0) begin
        $error("result transaction with no report pending");
        err_count++;
      end else begin
        want = pending_rpts.pop_front();
        check_field("packet_dropped", int'(want.dropped), int'(out_if.packet_dropped));
        check_field("pos_x", int'(want.pos_x), int'(out_if.pos_x));
        check_field("pos_y", int'(want.pos_y), int'(out_if.pos_y));
        check_field("left_button", int'(want.left), int'(out_if.left_button));
        check_field("right_button", int'(want.right), int'(out_if.right_button));
      end
      rx_stall_left = rx_stall_on ? $urandom_range(0, 12) : 0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left = rx_stall_left - 1;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [APB_DW-1:0] wv [N_PHASES];
    logic [APB_DW-1:0] hv [N_PHASES];
    int                phase_end;
    int                next_pause;

    in_if.valid   = 1'b0;
    in_if.rx_byte = '0;
    reset_tracker();

    // Screen sizes per phase: extremes, out-of-range, typical, random
    wv = '{32'd2, 32'd4096, 32'h0000_1FFF, 32'd0, 32'd640, 32'hFFFF_E001, 32'd1024, 32'd0};
    hv = '{32'd2, 32'd4096, 32'd1, 32'hABCD_1FFF, 32'd480, 32'd0, 32'd768, 32'd0};
    wv[N_PHASES-1] = $urandom_range(2, 4096);
    hv[N_PHASES-1] = $urandom;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset screen size
    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].rpt);
    wait_idle(4);

    // Random part, one screen setting per phase
    next_pause = items_sent + 150;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle(4);
      cfg_set(REG_WIDTH, wv[p]);
      cfg_set(REG_HEIGHT, hv[p]);
      tx_gaps_on  = (p % 3) != 1;
      rx_stall_on = (p % 4) != 2;
      phase_end = (p == N_PHASES - 1) ? TARGET_ITEMS : items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        send_random_unit();
        if (items_sent >= next_pause) begin
          wait_idle(0);
          next_pause = items_sent + 150;
        end
      end
    end

    wait_idle(DRAIN_CYCLES);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/ps2mc_pkg.sv
hdl/ps2mc_ifs.sv
hdl/ps2mc_cfg_regs.sv
hdl/ps2mc_axis.sv
hdl/ps2mc_core.sv
hdl/ps2_mouse_packet_cursor.sv
bench/ps2_mouse_packet_cursor_tb.sv
